@@ hw/rtl/lmsb_pkg.sv @@
// Shared types, constants and address helpers for the LED matrix shadow buffer.
`timescale 1ns / 1ps
`default_nettype none

package lmsb_pkg;

    localparam int MODULES         = 4;
    localparam int COLS_PER_MODULE = 8;
    localparam int TOTAL_COLS      = MODULES * COLS_PER_MODULE;
    localparam int ADDR_W          = $clog2(TOTAL_COLS);
    localparam int IN_W            = 24;
    localparam int OUT_W           = 24;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0]
    {
        KIND_SET_PIXEL,
        KIND_SET_ROW,
        KIND_CLEAR,
        KIND_FLUSH
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_END
    } state_t;

    typedef struct packed
    {
        kind_t      op;
        logic [2:0] row;
        logic       bit_on;
    } col_req_t;

    typedef struct packed
    {
        logic [7:0] work_next;
        logic [7:0] mask;
        logic       differs;
    } col_res_t;

    typedef struct packed
    {
        logic       work_we;
        logic       shown_we;
        logic [7:0] work_wdata;
    } frame_wr_t;

    function automatic addr_t col_addr(input logic [1:0] module_sel, input logic [2:0] col_sel);
        logic [31:0] w;
        w = 32'(module_sel) * 32'(COLS_PER_MODULE) + 32'(col_sel);
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic [1:0] col_module(input addr_t a);
        logic [31:0] w;
        w = 32'(a);
        return w[4:3];
    endfunction

    function automatic logic [2:0] col_index(input addr_t a);
        logic [31:0] w;
        w = 32'(a);
        return w[2:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lmsb_frames.sv @@
// Working and shown frame storage, one column address shared by both frames.
`timescale 1ns / 1ps
`default_nettype none

module lmsb_frames
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  lmsb_pkg::addr_t     addr,
    input  lmsb_pkg::frame_wr_t wr,
    output logic [7:0]          work_rdata,
    output logic [7:0]          shown_rdata
);

    logic [7:0] work_reg  [lmsb_pkg::TOTAL_COLS];
    logic [7:0] shown_reg [lmsb_pkg::TOTAL_COLS];

    assign work_rdata  = work_reg[addr];
    assign shown_rdata = shown_reg[addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lmsb_pkg::TOTAL_COLS; i++)
            begin
                work_reg[i]  <= 8'h00;
                shown_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (wr.work_we)
            begin
                work_reg[addr] <= wr.work_wdata;
            end
            // shown frame takes the current working column
            if (wr.shown_we)
            begin
                shown_reg[addr] <= work_reg[addr];
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lmsb_col_unit.sv @@
// Shared column unit: read-modify-write of one column byte and diff against shown.
`timescale 1ns / 1ps
`default_nettype none

module lmsb_col_unit
(
    input  lmsb_pkg::col_req_t req,
    input  wire [7:0]          cur,
    input  wire [7:0]          prev,
    output lmsb_pkg::col_res_t res
);

    logic [7:0] rbit;

    assign rbit = 8'(1) << req.row;

    always_comb
    begin
        case (req.op)
            lmsb_pkg::KIND_SET_PIXEL,
            lmsb_pkg::KIND_SET_ROW:
            begin
                res.work_next = req.bit_on ? (cur | rbit) : (cur & ~rbit);
            end
            lmsb_pkg::KIND_CLEAR:
            begin
                res.work_next = 8'h00;
            end
            default:
            begin
                res.work_next = cur;
            end
        endcase
        res.mask    = cur ^ prev;
        res.differs = |(cur ^ prev);
    end

endmodule

`default_nettype wire

@@ hw/rtl/lmsb_ctrl.sv @@
// Sequencer: item capture, column stepping, pending result and output register.
`timescale 1ns / 1ps
`default_nettype none

module lmsb_ctrl
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    input  wire [lmsb_pkg::IN_W-1:0]  s_tdata,
    input  wire [1:0]                 s_tuser,
    output logic                      m_tvalid,
    input  wire                       m_tready,
    output logic [lmsb_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tlast,
    output lmsb_pkg::addr_t           addr,
    output lmsb_pkg::col_req_t        req,
    output lmsb_pkg::frame_wr_t       wr,
    input  lmsb_pkg::col_res_t        res,
    input  wire [7:0]                 work_rdata
);

    lmsb_pkg::state_t state_reg, state_next;
    lmsb_pkg::kind_t  kind_reg;
    lmsb_pkg::kind_t  in_kind;
    logic [1:0]       mod_reg;
    logic [2:0]       row_reg;
    logic [2:0]       col_reg;
    logic             pixel_reg;
    logic [7:0]       bits_reg;
    lmsb_pkg::addr_t  cnt_reg;

    logic             pend_valid_reg;
    lmsb_pkg::addr_t  pend_addr_reg;
    logic [7:0]       pend_mask_reg;
    logic [7:0]       pend_bits_reg;

    logic                       out_valid_reg;
    logic [lmsb_pkg::OUT_W-1:0] out_data_reg;
    logic                       out_last_reg;

    logic accept;
    logic mod_ok;
    logic write_last;
    logic scan_last;
    logic out_free;
    logic scan_stall;
    logic push_pend;
    logic push_last;
    logic take_new;

    assign s_tready = (state_reg == lmsb_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_kind  = lmsb_pkg::kind_t'(s_tuser);
    assign mod_ok   = int'(s_tdata[1:0]) < lmsb_pkg::MODULES;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign addr = (state_reg == lmsb_pkg::ST_SCAN) ? cnt_reg :
                  (kind_reg == lmsb_pkg::KIND_SET_PIXEL) ?
                      lmsb_pkg::col_addr(mod_reg, col_reg) :
                      lmsb_pkg::col_addr(mod_reg, cnt_reg[2:0]);

    assign req.op     = (state_reg == lmsb_pkg::ST_SCAN) ? lmsb_pkg::KIND_FLUSH : kind_reg;
    assign req.row    = row_reg;
    assign req.bit_on = (kind_reg == lmsb_pkg::KIND_SET_PIXEL) ? pixel_reg
                                                               : bits_reg[cnt_reg[2:0]];

    assign write_last = (kind_reg == lmsb_pkg::KIND_SET_PIXEL) || (cnt_reg[2:0] == 3'd7);
    assign scan_last  = (cnt_reg == lmsb_pkg::ADDR_W'(lmsb_pkg::TOTAL_COLS - 1));
    assign out_free   = !out_valid_reg || m_tready;
    // a new diff needs the pending slot, which can only drain into a free output
    assign scan_stall = res.differs && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmsb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == lmsb_pkg::KIND_FLUSH)
                    begin
                        state_next = lmsb_pkg::ST_SCAN;
                    end
                    else if (mod_ok)
                    begin
                        state_next = lmsb_pkg::ST_WRITE;
                    end
                end
            end
            lmsb_pkg::ST_WRITE:
            begin
                if (write_last)
                begin
                    state_next = lmsb_pkg::ST_IDLE;
                end
            end
            lmsb_pkg::ST_SCAN:
            begin
                if (!scan_stall && scan_last)
                begin
                    state_next = lmsb_pkg::ST_END;
                end
            end
            lmsb_pkg::ST_END:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = lmsb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lmsb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr.work_we    = 1'b0;
        wr.shown_we   = 1'b0;
        wr.work_wdata = res.work_next;
        push_pend     = 1'b0;
        push_last     = 1'b0;
        case (state_reg)
            lmsb_pkg::ST_WRITE:
            begin
                wr.work_we = 1'b1;
            end
            lmsb_pkg::ST_SCAN:
            begin
                wr.shown_we = res.differs && !scan_stall;
                push_pend   = res.differs && !scan_stall && pend_valid_reg;
            end
            lmsb_pkg::ST_END:
            begin
                push_pend = pend_valid_reg && out_free;
                push_last = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign take_new = wr.shown_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lmsb_pkg::ST_IDLE;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == lmsb_pkg::ST_WRITE ||
                     (state_reg == lmsb_pkg::ST_SCAN && !scan_stall))
            begin
                cnt_reg <= cnt_reg + lmsb_pkg::ADDR_W'(1);
            end
            if (take_new)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (push_pend)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push_pend)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= in_kind;
            mod_reg   <= s_tdata[1:0];
            row_reg   <= s_tdata[4:2];
            col_reg   <= s_tdata[7:5];
            pixel_reg <= s_tdata[8];
            bits_reg  <= s_tdata[16:9];
        end
        if (take_new)
        begin
            pend_addr_reg <= cnt_reg;
            pend_mask_reg <= res.mask;
            pend_bits_reg <= work_rdata;
        end
        if (push_pend)
        begin
            out_data_reg <= {3'b000, pend_bits_reg, pend_mask_reg,
                             lmsb_pkg::col_index(pend_addr_reg),
                             lmsb_pkg::col_module(pend_addr_reg)};
            out_last_reg <= push_last;
        end
    end

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_valid_reg)
        else $error("pending result left over when idle");

    a_pending_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == lmsb_pkg::ST_SCAN || state_reg == lmsb_pkg::ST_END))
        else $error("pending result outside a flush");

    a_work_write_only_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lmsb_pkg::ST_WRITE) |-> !wr.work_we)
        else $error("working frame written outside a write item");

    a_stall_holds_column: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lmsb_pkg::ST_SCAN && scan_stall) |=> $stable(cnt_reg))
        else $error("scan advanced while stalled");

endmodule

`default_nettype wire

@@ hw/rtl/led_matrix_shadow_buffer_diff.sv @@
// LED matrix shadow buffer with change extraction: top level.
//
// Input stream (s_*): one item per transfer. s_tuser carries the kind:
// set pixel, set row, clear module or flush. Set pixel is accepted, then
// done in one read-modify-write step; set row and clear module are accepted,
// then take one step per column of the module. A flush walks every column
// of the frame through the one shared column unit, one column a cycle while
// the output does not stall. s_tready is high only while no item is in work.
// Output stream (m_*): one transfer per column that differs from the shown
// frame, in ascending column order, with m_tlast on the final one of the
// flush. A flush with no changes produces no transfer. Each result waits in a
// pending slot until the next changed column or the end of the scan decides
// tlast, then is passed on through the output register.
// When the receiver stalls, the scan halts at the next changed column until
// the output register drains.
// Reset clears both frames, the sequencer and the output register.
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_shadow_buffer_diff
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        s_tvalid,
    output logic                       s_tready,
    // [1:0] module_req, [4:2] row, [7:5] col, [8] pixel_on, [16:9] row_bits, zero fill
    input  wire [lmsb_pkg::IN_W-1:0]   s_tdata,
    // [1:0] kind
    input  wire [1:0]                  s_tuser,
    output logic                       m_tvalid,
    input  wire                        m_tready,
    // [1:0] out_module, [4:2] out_col, [12:5] change_mask, [20:13] column_bits, zero fill
    output logic [lmsb_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tlast
);

    lmsb_pkg::addr_t     addr;
    lmsb_pkg::col_req_t  req;
    lmsb_pkg::col_res_t  res;
    lmsb_pkg::frame_wr_t wr;
    logic [7:0]          work_rdata;
    logic [7:0]          shown_rdata;

    lmsb_frames u_frames
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .addr        (addr),
        .wr          (wr),
        .work_rdata  (work_rdata),
        .shown_rdata (shown_rdata)
    );

    lmsb_col_unit u_col_unit
    (
        .req  (req),
        .cur  (work_rdata),
        .prev (shown_rdata),
        .res  (res)
    );

    lmsb_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .addr       (addr),
        .req        (req),
        .wr         (wr),
        .res        (res),
        .work_rdata (work_rdata)
    );

endmodule

`default_nettype wire

@@ sim/lmsb_diff_checker.sv @@
// Checker for the LED matrix shadow buffer: tracks both frames, predicts flush transfers.
`timescale 1ns / 1ps

module lmsb_diff_checker
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_tvalid,
    input  wire                          s_tready,
    // [1:0] module_req, [4:2] row, [7:5] col, [8] pixel_on, [16:9] row_bits, zero fill
    input  wire [lmsb_pkg::IN_W-1:0]     s_tdata,
    // [1:0] kind
    input  wire [1:0]                    s_tuser,
    input  wire                          m_tvalid,
    input  wire                          m_tready,
    // [1:0] out_module, [4:2] out_col, [12:5] change_mask, [20:13] column_bits, zero fill
    input  wire [lmsb_pkg::OUT_W-1:0]    m_tdata,
    input  wire                          m_tlast,
    output int                           fail_count,
    output int                           expected_left,
    output int                           changes_seen
);

    typedef struct packed
    {
        logic [1:0] mod_idx;
        logic [2:0] col_idx;
        logic [7:0] mask;
        logic [7:0] bits;
        logic       is_last;
    } col_change_t;

    logic [7:0]  work_cols  [lmsb_pkg::TOTAL_COLS];
    logic [7:0]  shown_cols [lmsb_pkg::TOTAL_COLS];
    col_change_t change_q [$];
    col_change_t want;
    col_change_t got;
    col_change_t held;
    logic        have_held;
    logic [1:0]  wr_mod;
    logic [2:0]  wr_row;
    logic [2:0]  wr_col;
    logic        wr_on;
    logic [7:0]  wr_bits;
    int          base;
    int          mismatches;
    int          transfers;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int x = 0; x < lmsb_pkg::TOTAL_COLS; x++)
            begin
                work_cols[x]  = 8'h00;
                shown_cols[x] = 8'h00;
            end
            change_q.delete();
            mismatches = 0;
            transfers  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.mod_idx = m_tdata[1:0];
                got.col_idx = m_tdata[4:2];
                got.mask    = m_tdata[12:5];
                got.bits    = m_tdata[20:13];
                got.is_last = m_tlast;
                transfers++;
                if (change_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected transfer mod=%0d col=%0d mask=%02h %s",
                                 $time, got.mod_idx, got.col_idx, got.mask,
                                 $sformatf("bits=%02h last=%0b", got.bits, got.is_last));
                end
                else
                begin
                    want = change_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch exp mod=%0d col=%0d mask=%02h %s",
                                     $time, want.mod_idx, want.col_idx, want.mask,
                                     $sformatf("bits=%02h last=%0b", want.bits,
                                               want.is_last));
                            $display("%0t:          got mod=%0d col=%0d mask=%02h %s",
                                     $time, got.mod_idx, got.col_idx, got.mask,
                                     $sformatf("bits=%02h last=%0b", got.bits,
                                               got.is_last));
                        end
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                wr_mod  = s_tdata[1:0];
                wr_row  = s_tdata[4:2];
                wr_col  = s_tdata[7:5];
                wr_on   = s_tdata[8];
                wr_bits = s_tdata[16:9];
                base    = int'(wr_mod) * lmsb_pkg::COLS_PER_MODULE;
                if (lmsb_pkg::kind_t'(s_tuser) == lmsb_pkg::KIND_FLUSH)
                begin
                    // last flag is only known once the next change (or scan end) shows up
                    have_held = 1'b0;
                    for (int x = 0; x < lmsb_pkg::TOTAL_COLS; x++)
                    begin
                        if (work_cols[x] != shown_cols[x])
                        begin
                            if (have_held)
                                change_q.push_back(held);
                            held.mod_idx  = 2'(x / lmsb_pkg::COLS_PER_MODULE);
                            held.col_idx  = 3'(x % lmsb_pkg::COLS_PER_MODULE);
                            held.mask     = work_cols[x] ^ shown_cols[x];
                            held.bits     = work_cols[x];
                            held.is_last  = 1'b0;
                            shown_cols[x] = work_cols[x];
                            have_held     = 1'b1;
                        end
                    end
                    if (have_held)
                    begin
                        held.is_last = 1'b1;
                        change_q.push_back(held);
                    end
                end
                else if (int'(wr_mod) < lmsb_pkg::MODULES)
                begin
                    case (lmsb_pkg::kind_t'(s_tuser))
                        lmsb_pkg::KIND_SET_PIXEL:
                            work_cols[base + int'(wr_col)][wr_row] = wr_on;
                        lmsb_pkg::KIND_SET_ROW:
                            for (int c = 0; c < lmsb_pkg::COLS_PER_MODULE; c++)
                                work_cols[base + c][wr_row] = wr_bits[c];
                        default:
                            for (int c = 0; c < lmsb_pkg::COLS_PER_MODULE; c++)
                                work_cols[base + c] = 8'h00;
                    endcase
                end
            end
        end
        fail_count    <= mismatches;
        expected_left <= change_q.size();
        changes_seen  <= transfers;
    end

endmodule

@@ sim/tb_led_matrix_shadow_buffer_diff.sv @@
// Testbench top for the LED matrix shadow buffer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_led_matrix_shadow_buffer_diff;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 20;

    logic                        clk;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [lmsb_pkg::IN_W-1:0]   s_tdata;
    logic [1:0]                  s_tuser;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [lmsb_pkg::OUT_W-1:0]  m_tdata;
    logic                        m_tlast;

    int fail_count;
    int expected_left;
    int changes_seen;

    int src_idle_pct;
    int dst_stall_pct;
    int hold_req;
    int hold_seen;
    int hold_left;
    int cycles;
    int items_sent;
    int flushes_sent;

    int src_pct_tab [4] = '{0, 58, 0, 8};
    int dst_pct_tab [4] = '{0, 0, 58, 8};

    led_matrix_shadow_buffer_diff DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    lmsb_diff_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .expected_left (expected_left),
        .changes_seen  (changes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d transfers still expected",
                         cycles, expected_left);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever hold_req is bumped.
    initial
    begin
        m_tready  = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n)
                m_tready <= 1'b0;
            else if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    task automatic send_item(input lmsb_pkg::kind_t kind, input logic [1:0] mod_sel,
                             input logic [2:0] row, input logic [2:0] col,
                             input logic on, input logic [7:0] bits);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'b0, bits, on, col, row, mod_sel};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (kind == lmsb_pkg::KIND_FLUSH)
            flushes_sent++;
    endtask

    task automatic send_random();
        int              pick;
        lmsb_pkg::kind_t kind;
        pick = $urandom_range(99);
        if (pick < 30)
            kind = lmsb_pkg::KIND_SET_PIXEL;
        else if (pick < 55)
            kind = lmsb_pkg::KIND_SET_ROW;
        else if (pick < 65)
            kind = lmsb_pkg::KIND_CLEAR;
        else
            kind = lmsb_pkg::KIND_FLUSH;
        send_item(kind, 2'($urandom), 3'($urandom), 3'($urandom), 1'($urandom),
                  8'($urandom));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = lmsb_pkg::KIND_SET_PIXEL;
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        hold_req      = 0;
        items_sent    = 0;
        flushes_sent  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: flush of an untouched frame, corners, full rows, clears
        send_item(lmsb_pkg::KIND_FLUSH, 2'($urandom), 3'($urandom), 3'($urandom),
                  1'($urandom), 8'($urandom));
        send_item(lmsb_pkg::KIND_SET_PIXEL, 2'd0, 3'd0, 3'd0, 1'b1, 8'($urandom));
        send_item(lmsb_pkg::KIND_SET_PIXEL, 2'd3, 3'd7, 3'd7, 1'b1, 8'($urandom));
        send_item(lmsb_pkg::KIND_SET_ROW, 2'd1, 3'd3, 3'($urandom), 1'($urandom), 8'hFF);
        send_item(lmsb_pkg::KIND_SET_ROW, 2'd2, 3'd7, 3'($urandom), 1'($urandom), 8'hA5);
        send_item(lmsb_pkg::KIND_FLUSH, 2'd3, 3'd7, 3'd7, 1'b1, 8'hFF);
        send_item(lmsb_pkg::KIND_FLUSH, 2'd0, 3'd0, 3'd0, 1'b0, 8'h00);
        send_item(lmsb_pkg::KIND_SET_PIXEL, 2'd3, 3'd7, 3'd7, 1'b0, 8'($urandom));
        send_item(lmsb_pkg::KIND_SET_ROW, 2'd1, 3'd3, 3'($urandom), 1'($urandom), 8'h00);
        send_item(lmsb_pkg::KIND_CLEAR, 2'd2, 3'($urandom), 3'($urandom), 1'($urandom),
                  8'($urandom));
        send_item(lmsb_pkg::KIND_FLUSH, 2'($urandom), 3'($urandom), 3'($urandom),
                  1'($urandom), 8'($urandom));
        // set then undo: working equals shown again, so no transfer
        send_item(lmsb_pkg::KIND_SET_PIXEL, 2'd0, 3'd5, 3'd2, 1'b1, 8'($urandom));
        send_item(lmsb_pkg::KIND_SET_PIXEL, 2'd0, 3'd5, 3'd2, 1'b0, 8'($urandom));
        send_item(lmsb_pkg::KIND_FLUSH, 2'($urandom), 3'($urandom), 3'($urandom),
                  1'($urandom), 8'($urandom));
        // every column differs: largest flush
        for (int m = 0; m < lmsb_pkg::MODULES; m++)
        begin
            send_item(lmsb_pkg::KIND_SET_ROW, 2'(m), 3'd0, 3'($urandom), 1'($urandom),
                      8'hFF);
            send_item(lmsb_pkg::KIND_SET_ROW, 2'(m), 3'd7, 3'($urandom), 1'($urandom),
                      8'hFF);
        end
        send_item(lmsb_pkg::KIND_FLUSH, 2'($urandom), 3'($urandom), 3'($urandom),
                  1'($urandom), 8'($urandom));
        send_item(lmsb_pkg::KIND_CLEAR, 2'd0, 3'($urandom), 3'($urandom), 1'($urandom),
                  8'($urandom));
        send_item(lmsb_pkg::KIND_FLUSH, 2'($urandom), 3'($urandom), 3'($urandom),
                  1'($urandom), 8'($urandom));

        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct  = src_pct_tab[p];
            dst_stall_pct = dst_pct_tab[p];
            repeat (PHASE_ITEMS) send_random();
        end

        // long receiver hold while input keeps coming: block backs up on a flush
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        hold_req++;
        repeat (3)
        begin
            repeat (4)
                send_item(lmsb_pkg::KIND_SET_ROW, 2'($urandom), 3'($urandom),
                          3'($urandom), 1'($urandom), 8'($urandom));
            send_item(lmsb_pkg::KIND_FLUSH, 2'($urandom), 3'($urandom), 3'($urandom),
                      1'($urandom), 8'($urandom));
        end
        s_tvalid <= 1'b0;

        // let the checker post its count for the final transfer
        repeat (2) @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d items (%0d flushes), checked %0d column-change transfers",
                 items_sent, flushes_sent, changes_seen);
        $display("Idle/stall mixes: none, sender 58%%, receiver 58%%, both 8%%, %s",
                 $sformatf("plus a %0d-cycle hold", HOLD_CYCLES));
        if (expected_left != 0)
            $display("%0d expected transfers never arrived", expected_left);
        if (fail_count == 0 && expected_left == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
